/* hw/rtl/srdu_pkg.sv */
// Package for the segmented reduce unit: item types, mode codes and constants.
`default_nettype none

package srdu_pkg;

    // Element and result data width.
    localparam int DataWidth = 32;
    // Element position counter width.
    localparam int PosWidth = 31;

    // Mode register codes; the unused code gives a plain zero result.
    typedef logic [2:0] mode_t;
    localparam mode_t MODE_SUM             = 3'd0;
    localparam mode_t MODE_MIN             = 3'd1;
    localparam mode_t MODE_MAX             = 3'd2;
    localparam mode_t MODE_WHICH_MIN       = 3'd3;
    localparam mode_t MODE_WHICH_MAX       = 3'd4;
    localparam mode_t MODE_UNSORTED        = 3'd5;
    localparam mode_t MODE_STRICT_UNSORTED = 3'd6;
    localparam mode_t MODE_UNUSED          = 3'd7;

    // Configuration register indexes.
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_MODE      = 1'b0;
    localparam cfg_index_t CFG_NA_REMOVE = 1'b1;

    // Start values and the NA marker.
    localparam logic signed [DataWidth-1:0] MinInit = 32'sh7FFF_FFFF;
    localparam logic signed [DataWidth-1:0] MaxInit = 32'sh8000_0001;
    localparam logic signed [DataWidth-1:0] NaCode  = 32'sh8000_0000;
    localparam logic [PosWidth-1:0]         PosMax  = 31'h7FFF_FFFF;

    // One input item.
    typedef struct packed {
        logic signed [DataWidth-1:0] value;
        logic                        value_is_na;
        logic                        segment_end;
        logic                        empty_segment;
    } item_t;

    // One result item.
    typedef struct packed {
        logic signed [DataWidth-1:0] result;
        logic                        result_is_na;
        logic                        overflow;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/srdu_accum.sv */
// Running segment state of the segmented reduce unit and its per-item update.
`default_nettype none

module srdu_accum
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 advance,
    input  wire srdu_pkg::item_t item,
    input  wire srdu_pkg::mode_t mode,
    input  wire                 na_remove,
    output srdu_pkg::result_t   res
);

    logic signed [srdu_pkg::DataWidth-1:0] acc_reg, acc_next;
    logic signed [srdu_pkg::DataWidth-1:0] prev_reg, prev_next;
    logic [srdu_pkg::PosWidth-1:0]         pos_reg, pos_next;
    logic [srdu_pkg::PosWidth-1:0]         best_reg, best_next;
    logic done_reg, done_next;
    logic na_seen_reg, na_seen_next;
    logic ovf_reg, ovf_next;
    logic have_reg, have_next;

    logic signed [srdu_pkg::DataWidth-1:0] base;
    logic signed [srdu_pkg::DataWidth-1:0] sum;
    logic closes;
    logic which_mode;

    assign closes     = item.empty_segment | item.segment_end;
    assign which_mode = (mode == srdu_pkg::MODE_WHICH_MIN) |
                        (mode == srdu_pkg::MODE_WHICH_MAX);

    // Fold the element into the running state.
    always_comb
    begin
        acc_next     = acc_reg;
        prev_next    = prev_reg;
        pos_next     = pos_reg;
        best_next    = best_reg;
        done_next    = done_reg;
        na_seen_next = na_seen_reg;
        ovf_next     = ovf_reg;
        have_next    = have_reg;
        base         = acc_reg;
        sum          = acc_reg;
        if (!item.empty_segment)
        begin
            if (pos_reg != srdu_pkg::PosMax)
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (!done_reg && (mode != srdu_pkg::MODE_UNUSED))
            begin
                if (item.value_is_na)
                begin
                    if (!which_mode && !na_remove)
                    begin
                        na_seen_next = 1'b1;
                        done_next    = 1'b1;
                    end
                end
                else
                begin
                    have_next = 1'b1;
                    unique case (mode)
                        srdu_pkg::MODE_SUM:
                        begin
                            base = have_reg ? acc_reg : '0;
                            sum  = base + item.value;
                            if (((base ^ sum) & (item.value ^ sum)) < 0)
                            begin
                                ovf_next = 1'b1;
                            end
                            acc_next = sum;
                        end
                        srdu_pkg::MODE_MIN, srdu_pkg::MODE_WHICH_MIN:
                        begin
                            base = have_reg ? acc_reg : srdu_pkg::MinInit;
                            acc_next = base;
                            if (item.value < base)
                            begin
                                acc_next = item.value;
                                if (mode == srdu_pkg::MODE_WHICH_MIN)
                                begin
                                    best_next = pos_next;
                                end
                            end
                        end
                        srdu_pkg::MODE_MAX, srdu_pkg::MODE_WHICH_MAX:
                        begin
                            base = have_reg ? acc_reg : srdu_pkg::MaxInit;
                            acc_next = base;
                            if (item.value > base)
                            begin
                                acc_next = item.value;
                                if (mode == srdu_pkg::MODE_WHICH_MAX)
                                begin
                                    best_next = pos_next;
                                end
                            end
                        end
                        default:
                        begin
                            // Both unsorted variants compare with the previous element.
                            if (have_reg &&
                                ((mode == srdu_pkg::MODE_STRICT_UNSORTED) ?
                                 (item.value <= prev_reg) : (item.value < prev_reg)))
                            begin
                                done_next = 1'b1;
                            end
                            prev_next = item.value;
                        end
                    endcase
                end
            end
        end
    end

    // Result of a closing segment, taken from the updated state.
    always_comb
    begin
        res = '0;
        if (mode == srdu_pkg::MODE_UNUSED)
        begin
            res = '0;
        end
        else if (na_seen_next)
        begin
            res.result       = srdu_pkg::NaCode;
            res.result_is_na = 1'b1;
        end
        else
        begin
            unique case (mode)
                srdu_pkg::MODE_SUM:
                begin
                    res.result   = have_next ? acc_next : '0;
                    res.overflow = ovf_next;
                end
                srdu_pkg::MODE_MIN:
                begin
                    res.result = have_next ? acc_next : srdu_pkg::MinInit;
                end
                srdu_pkg::MODE_MAX:
                begin
                    res.result = have_next ? acc_next : srdu_pkg::MaxInit;
                end
                srdu_pkg::MODE_WHICH_MIN, srdu_pkg::MODE_WHICH_MAX:
                begin
                    if (best_next == '0)
                    begin
                        res.result       = srdu_pkg::NaCode;
                        res.result_is_na = 1'b1;
                    end
                    else
                    begin
                        res.result = {1'b0, best_next};
                    end
                end
                default:
                begin
                    res.result = {{(srdu_pkg::DataWidth-1){1'b0}}, done_next};
                end
            endcase
        end
    end

    // State registers; a closed segment starts the next one from scratch.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            prev_reg    <= '0;
            pos_reg     <= '0;
            best_reg    <= '0;
            done_reg    <= 1'b0;
            na_seen_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            have_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (closes)
            begin
                acc_reg     <= '0;
                prev_reg    <= '0;
                pos_reg     <= '0;
                best_reg    <= '0;
                done_reg    <= 1'b0;
                na_seen_reg <= 1'b0;
                ovf_reg     <= 1'b0;
                have_reg    <= 1'b0;
            end
            else
            begin
                acc_reg     <= acc_next;
                prev_reg    <= prev_next;
                pos_reg     <= pos_next;
                best_reg    <= best_next;
                done_reg    <= done_next;
                na_seen_reg <= na_seen_next;
                ovf_reg     <= ovf_next;
                have_reg    <= have_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/segmented_reduce_unit.sv */
// A closing item passes the input register and then the result register before m_tvalid.
// One item per cycle unless a closing item waits on a held result; the single add or
// compare against the running state sits between the input register and the result register.
// A stalled result holds only closing items; non-closing items keep flowing.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the running
// segment state and sets mode to sum with NA removal off.
`default_nettype none

module segmented_reduce_unit
(
    input  wire         clk,
    input  wire         rst_n,
    // Input stream.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] value
    input  wire  [1:0]  s_tuser,   // [0] value_is_na, [1] empty_segment
    input  wire         s_tlast,   // segment_end
    // Result stream.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] result
    output logic [1:0]  m_tuser,   // [0] result_is_na, [1] overflow
    // Configuration writes.
    input  wire         cfg_we,
    input  wire  [0:0]  cfg_index,
    input  wire  [2:0]  cfg_data
);

    srdu_pkg::mode_t   mode_reg;
    logic              na_remove_reg;
    logic              in_valid_reg;
    srdu_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    srdu_pkg::result_t out_reg;
    srdu_pkg::result_t res;
    logic              closes;
    logic              advance;

    assign closes   = in_item_reg.empty_segment | in_item_reg.segment_end;
    assign advance  = in_valid_reg & (~closes | ~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= srdu_pkg::MODE_SUM;
            na_remove_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srdu_pkg::CFG_MODE:      mode_reg      <= cfg_data;
                srdu_pkg::CFG_NA_REMOVE: na_remove_reg <= cfg_data[0];
                default:                 mode_reg      <= mode_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.value         <= s_tdata;
            in_item_reg.value_is_na   <= s_tuser[0];
            in_item_reg.segment_end   <= s_tlast;
            in_item_reg.empty_segment <= s_tuser[1];
        end
    end

    // Running segment state.
    srdu_accum u_accum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (in_item_reg),
        .mode      (mode_reg),
        .na_remove (na_remove_reg),
        .res       (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && closes)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && closes)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.result;
    assign m_tuser  = {out_reg.overflow, out_reg.result_is_na};

endmodule

`default_nettype wire

/* verif/tb_segmented_reduce_unit.sv */
// Self-checking testbench for the segmented reduce unit: random streams checked against a predictor.
`timescale 1ns / 100ps

module tb_segmented_reduce_unit;

    localparam int CycleLimit = 200000;
    localparam int HoldCycles = 300;
    localparam int PhaseItems = 25;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;   // [0] value_is_na, [1] empty_segment
    logic        s_tlast = 1'b0; // segment_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [31:0] result
    logic [1:0]  m_tuser;        // [0] result_is_na, [1] overflow
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [2:0]  cfg_data = '0;

    segmented_reduce_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus, expectations and bookkeeping.
    srdu_pkg::item_t   pending[$];
    srdu_pkg::result_t reductions_due[$];
    srdu_pkg::item_t   next_item;
    srdu_pkg::result_t want_now;
    int      errors = 0;
    int      cycles = 0;
    int      hold_left = 0;
    int      phase_start;
    bit      in_taken = 1'b0;
    bit      stall_request = 1'b0;
    bit      src_idle_en = 1'b1;
    bit      snk_idle_en = 1'b1;

    // Predictor copy of the configuration and of the running segment state.
    srdu_pkg::mode_t   cur_mode = srdu_pkg::MODE_SUM;
    bit                cur_na_rm = 1'b0;
    logic [31:0]       run_acc = '0;
    logic [srdu_pkg::PosWidth-1:0] lead_pos = '0;
    logic [srdu_pkg::PosWidth-1:0] elem_count = '0;
    logic [31:0]       last_value = '0;
    bit                seg_settled = 1'b0;
    bit                na_hit = 1'b0;
    bit                sum_wrapped = 1'b0;
    bit                any_value = 1'b0;

    // Fold one element into the running segment state.
    function automatic void absorb_element(input logic [31:0] v, input bit is_na);
        logic [31:0] base;
        logic [31:0] total;
        if (elem_count != srdu_pkg::PosMax)
            elem_count = elem_count + 1'b1;
        if (seg_settled || cur_mode == srdu_pkg::MODE_UNUSED)
            return;
        if (is_na)
        begin
            if (cur_mode == srdu_pkg::MODE_WHICH_MIN || cur_mode == srdu_pkg::MODE_WHICH_MAX ||
                cur_na_rm)
                return;
            na_hit = 1'b1;
            seg_settled = 1'b1;
            return;
        end
        case (cur_mode)
            srdu_pkg::MODE_SUM:
            begin
                base = any_value ? run_acc : 32'd0;
                total = base + v;
                if ((base[31] ^ total[31]) & (v[31] ^ total[31]))
                    sum_wrapped = 1'b1;
                run_acc = total;
            end
            srdu_pkg::MODE_MIN, srdu_pkg::MODE_WHICH_MIN:
            begin
                base = any_value ? run_acc : srdu_pkg::MinInit;
                if ($signed(v) < $signed(base))
                begin
                    base = v;
                    if (cur_mode == srdu_pkg::MODE_WHICH_MIN)
                        lead_pos = elem_count;
                end
                run_acc = base;
            end
            srdu_pkg::MODE_MAX, srdu_pkg::MODE_WHICH_MAX:
            begin
                base = any_value ? run_acc : srdu_pkg::MaxInit;
                if ($signed(v) > $signed(base))
                begin
                    base = v;
                    if (cur_mode == srdu_pkg::MODE_WHICH_MAX)
                        lead_pos = elem_count;
                end
                run_acc = base;
            end
            default:
            begin
                if (any_value && (cur_mode == srdu_pkg::MODE_STRICT_UNSORTED ?
                                  $signed(v) <= $signed(last_value) :
                                  $signed(v) < $signed(last_value)))
                    seg_settled = 1'b1;
                last_value = v;
            end
        endcase
        any_value = 1'b1;
    endfunction

    // Produce the result of the closing segment and start a fresh one.
    function automatic srdu_pkg::result_t close_reduction();
        srdu_pkg::result_t r;
        r = '0;
        if (cur_mode == srdu_pkg::MODE_UNUSED)
            r.result = '0;
        else if (na_hit)
        begin
            r.result = srdu_pkg::NaCode;
            r.result_is_na = 1'b1;
        end
        else
        begin
            case (cur_mode)
                srdu_pkg::MODE_SUM:
                begin
                    r.result = any_value ? run_acc : 32'd0;
                    r.overflow = sum_wrapped;
                end
                srdu_pkg::MODE_MIN:
                    r.result = any_value ? run_acc : srdu_pkg::MinInit;
                srdu_pkg::MODE_MAX:
                    r.result = any_value ? run_acc : srdu_pkg::MaxInit;
                srdu_pkg::MODE_WHICH_MIN, srdu_pkg::MODE_WHICH_MAX:
                begin
                    if (lead_pos == '0)
                    begin
                        r.result = srdu_pkg::NaCode;
                        r.result_is_na = 1'b1;
                    end
                    else
                        r.result = {1'b0, lead_pos};
                end
                default:
                    r.result = seg_settled ? 32'd1 : 32'd0;
            endcase
        end
        run_acc = '0;
        lead_pos = '0;
        elem_count = '0;
        last_value = '0;
        seg_settled = 1'b0;
        na_hit = 1'b0;
        sum_wrapped = 1'b0;
        any_value = 1'b0;
        return r;
    endfunction

    // Biased element values: extremes, small values with ties, or anything.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0:
            begin
                case ($urandom_range(5))
                    0: return 32'h7FFF_FFFF;
                    1: return srdu_pkg::MaxInit;
                    2: return srdu_pkg::NaCode;
                    3: return 32'h0;
                    4: return 32'hFFFF_FFFF;
                    default: return 32'h7FFF_FFFE;
                endcase
            end
            1: return $urandom_range(16) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input logic [31:0] v, input bit na, input bit last, input bit empty);
        srdu_pkg::item_t it;
        it.value = v;
        it.value_is_na = na;
        it.segment_end = last;
        it.empty_segment = empty;
        pending.push_back(it);
    endtask

    // One segment of random content; ascending ones keep the unsorted modes busy.
    task automatic push_segment(input bit ascending);
        int len;
        logic [31:0] v;
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
        v = $urandom_range(20) - 10;
        for (int k = 0; k < len; k++)
        begin
            if (ascending)
                v = v + $urandom_range(2);
            else
                v = pick_value();
            // A final item without the end marker lets the segment run into the next one.
            push_item(v, $urandom_range(7) == 0,
                      (k == len - 1) && ($urandom_range(15) != 0), 1'b0);
        end
    endtask

    task automatic write_regs(input srdu_pkg::mode_t m, input bit drop_na);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= srdu_pkg::CFG_MODE;
        cfg_data <= m;
        @(negedge clk);
        cfg_index <= srdu_pkg::CFG_NA_REMOVE;
        cfg_data <= {2'b00, drop_na};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every item is in and every result is out, then let the pipeline settle.
    task automatic wait_drained();
        while (pending.size() != 0 || s_tvalid || reductions_due.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Input driver: a new transfer is offered once the previous one has gone.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (pending.size() != 0 && !(src_idle_en && $urandom_range(99) < 20))
            begin
                next_item = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_item.value;
                s_tuser <= {next_item.empty_segment, next_item.value_is_na};
                s_tlast <= next_item.segment_end;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver: random back-pressure, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (stall_request)
        begin
            hold_left = HoldCycles;
            stall_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(snk_idle_en && $urandom_range(99) < 20);
    end

    // Monitor: tracks register writes, checks results and predicts from accepted items.
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("tb_segmented_reduce_unit: errors");
            $finish;
        end
        else
        begin
            in_taken = rst_n && s_tvalid && s_tready;
            if (rst_n && cfg_we)
            begin
                if (cfg_index == srdu_pkg::CFG_MODE)
                    cur_mode = srdu_pkg::mode_t'(cfg_data);
                else
                    cur_na_rm = cfg_data[0];
            end
            if (rst_n && m_tvalid && m_tready)
            begin
                if (reductions_due.size() == 0)
                begin
                    $error("unexpected result transfer: result %0d", $signed(m_tdata));
                    errors = errors + 1;
                end
                else
                begin
                    want_now = reductions_due.pop_front();
                    if (m_tdata !== want_now.result)
                    begin
                        $error("result: expected %0d, actual %0d",
                               $signed(want_now.result), $signed(m_tdata));
                        errors = errors + 1;
                    end
                    if (m_tuser[0] !== want_now.result_is_na)
                    begin
                        $error("result_is_na: expected %0b, actual %0b",
                               want_now.result_is_na, m_tuser[0]);
                        errors = errors + 1;
                    end
                    if (m_tuser[1] !== want_now.overflow)
                    begin
                        $error("overflow: expected %0b, actual %0b",
                               want_now.overflow, m_tuser[1]);
                        errors = errors + 1;
                    end
                end
            end
            if (in_taken)
            begin
                if (s_tuser[1])
                    reductions_due.push_back(close_reduction());
                else
                begin
                    absorb_element(s_tdata, s_tuser[0]);
                    if (s_tlast)
                        reductions_due.push_back(close_reduction());
                end
            end
        end
    end

    // Sequence: reset, then one phase per mode and NA setting.
    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        for (int ph = 0; ph < 16; ph++)
        begin
            wait_drained();
            write_regs(srdu_pkg::mode_t'(ph / 2), ph[0]);
            src_idle_en = !(ph == 2 || ph == 3 || ph == 9);
            snk_idle_en = !(ph == 2 || ph == 3);
            if (ph == 0)
            begin
                // Sum wrapping upward and downward, and the most negative code as a number.
                push_item(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
                push_item(32'h0000_0001, 1'b0, 1'b1, 1'b0);
                push_item(srdu_pkg::NaCode, 1'b0, 1'b0, 1'b0);
                push_item(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
                push_item(srdu_pkg::MaxInit, 1'b0, 1'b0, 1'b0);
                push_item(srdu_pkg::MaxInit, 1'b0, 1'b1, 1'b0);
                push_item(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
                push_item(srdu_pkg::MaxInit, 1'b0, 1'b1, 1'b0);
                // NA as the first element, then NA closing a segment.
                push_item(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
                push_item(32'h0000_0005, 1'b0, 1'b1, 1'b0);
                push_item(32'h0000_0003, 1'b0, 1'b0, 1'b0);
                push_item(32'h1234_5678, 1'b1, 1'b1, 1'b0);
                // Empty segments, with and without the end marker, junk in the value.
                push_item(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
                push_item(32'hA5A5_A5A5, 1'b1, 1'b1, 1'b1);
                // An empty item that cuts a running segment short.
                push_item(32'h0000_0009, 1'b0, 1'b0, 1'b0);
                push_item(32'h0000_0000, 1'b0, 1'b0, 1'b1);
                push_item(32'h0000_0000, 1'b0, 1'b1, 1'b0);
            end
            phase_start = pending.size();
            while (pending.size() - phase_start < PhaseItems)
            begin
                if ($urandom_range(99) < 8)
                    push_item($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
                else if (ph / 2 == 5 || ph / 2 == 6)
                    push_segment($urandom_range(99) < 60);
                else
                    push_segment($urandom_range(99) < 20);
            end
            if (ph == 9)
            begin
                // Hold the result side while items keep coming, so the input stalls.
                @(posedge clk);
                stall_request = 1'b1;
            end
        end
        wait_drained();
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("tb_segmented_reduce_unit: clean");
        else
            $display("tb_segmented_reduce_unit: errors");
        $finish;
    end

endmodule
